// ===== design/tarm_pkg.sv =====
// Package with types, constants and shared arithmetic of the two-angle rotation matrix.
`timescale 1ns / 1ps

package tarm_pkg;

  localparam int unsigned ANGLE_BITS    = 16;
  localparam int unsigned OUT_FRAC_BITS = 14;
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned PHASE_W       = 32;
  localparam int unsigned PHASE_SHIFT   = PHASE_W - ANGLE_BITS;
  localparam int unsigned Q_FRAC        = 30;
  localparam int unsigned T_W           = Q_FRAC + 1;
  localparam int unsigned SIN_W         = OUT_FRAC_BITS + 2;
  localparam int unsigned PROD_W        = 2 * SIN_W;
  localparam int unsigned ROUND_SH      = Q_FRAC - OUT_FRAC_BITS;

  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned NUM_CELLS  = 4;
  localparam int unsigned NUM_STAGES = NUM_CELLS + 4;

  localparam int unsigned LANE_SC = 0;
  localparam int unsigned LANE_CC = 1;
  localparam int unsigned LANE_SO = 2;
  localparam int unsigned LANE_CO = 3;

  localparam logic [PHASE_W-1:0] PHASE_QUARTER = PHASE_W'(1) << Q_FRAC;
  localparam logic [T_W-1:0]     Q30_ONE       = T_W'(1) << Q_FRAC;

  localparam logic [T_W-1:0] COEF_C1 = T_W'(1686629713);
  localparam logic [T_W-1:0] COEF_C3 = T_W'(693598668);
  localparam logic [T_W-1:0] COEF_C5 = T_W'(85569306);
  localparam logic [T_W-1:0] COEF_C7 = T_W'(5026995);
  localparam logic [T_W-1:0] COEF_C9 = T_W'(172272);

  localparam logic [T_W-1:0] HORNER_COEF [NUM_CELLS] = '{COEF_C7, COEF_C5, COEF_C3, COEF_C1};

  localparam logic [T_W:0] RND_HALF =
      (ROUND_SH > 0) ? ((T_W + 1)'(1) << (ROUND_SH - 1)) : '0;
  localparam logic [T_W:0] SAT_ONE = (T_W + 1)'(1) << OUT_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (OUT_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [FIELD_W-1:0] chi_angle;
    logic signed [FIELD_W-1:0] omega_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] r00;
    logic signed [FIELD_W-1:0] r01;
    logic signed [FIELD_W-1:0] r02;
    logic signed [FIELD_W-1:0] r10;
    logic signed [FIELD_W-1:0] r11;
    logic signed [FIELD_W-1:0] r12;
    logic signed [FIELD_W-1:0] r20;
    logic signed [FIELD_W-1:0] r21;
    logic signed [FIELD_W-1:0] r22;
  } out_item_t;

  typedef struct packed {
    logic           neg;
    logic [T_W-1:0] t;
    logic [T_W-1:0] t2;
    logic [T_W-1:0] h;
  } lane_t;

  function automatic logic [T_W-1:0] q30_mul(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
    logic [2*T_W-1:0] prod;
    prod = a * b;
    return prod[Q_FRAC+T_W-1:Q_FRAC];
  endfunction

endpackage

// ===== design/two_angle_rotation_matrix.sv =====
// Top level of the two-angle rotation matrix: handshake, phase front end and matrix products.
`timescale 1ns / 1ps

// Takes one angle pair (chi, omega; 65536 units per turn) per transfer and returns the nine
// Q1.14 entries of the sample rotation matrix. It takes a new pair every cycle unless it
// stalls the input. The result reaches the output after passing eight
// register stages: one phase stage, one squaring stage, a chain of four Horner cells per sine
// lane, a rounding stage and the product stage. A stage loads whenever it is empty or the
// stage after it is moving, so bubbles close up and new transfers are taken while a finished
// result waits at the output, until every stage holds an item.
module two_angle_rotation_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tarm_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tarm_pkg::out_item_t   out_data_o
);

  localparam int unsigned NS     = tarm_pkg::NUM_STAGES;
  localparam int unsigned NL     = tarm_pkg::NUM_LANES;
  localparam int unsigned NC     = tarm_pkg::NUM_CELLS;
  localparam int unsigned STG_SQ = 1;
  localparam int unsigned STG_C0 = 2;
  localparam int unsigned STG_FN = NC + 2;
  localparam int unsigned STG_OT = NC + 3;

  logic [NS-1:0] vld_d, vld_q, adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NS-1];

  function automatic tarm_pkg::lane_t phase_to_lane(input logic [tarm_pkg::PHASE_W-1:0] ph);
    tarm_pkg::lane_t                 ln;
    logic [tarm_pkg::T_W-1:0]        p;
    p      = {1'b0, ph[tarm_pkg::Q_FRAC-1:0]};
    ln.neg = ph[tarm_pkg::PHASE_W-1];
    ln.t   = ph[tarm_pkg::Q_FRAC] ? (tarm_pkg::Q30_ONE - p) : p;
    ln.t2  = '0;
    ln.h   = '0;
    return ln;
  endfunction

  logic [tarm_pkg::PHASE_W-1:0] ph_chi, ph_om;
  tarm_pkg::lane_t              front_d [NL];
  tarm_pkg::lane_t              front_q [NL];
  tarm_pkg::lane_t              chain   [NC+1][NL];
  tarm_pkg::lane_t              square_q[NL];

  always_comb begin
    ph_chi = {{(tarm_pkg::PHASE_W - tarm_pkg::FIELD_W){in_data_i.chi_angle[tarm_pkg::FIELD_W-1]}},
              in_data_i.chi_angle} << tarm_pkg::PHASE_SHIFT;
    ph_om  = {{(tarm_pkg::PHASE_W - tarm_pkg::FIELD_W){in_data_i.omega_angle[tarm_pkg::FIELD_W-1]}},
              in_data_i.omega_angle} << tarm_pkg::PHASE_SHIFT;
    front_d[tarm_pkg::LANE_SC] = phase_to_lane(ph_chi);
    front_d[tarm_pkg::LANE_CC] = phase_to_lane(ph_chi + tarm_pkg::PHASE_QUARTER);
    front_d[tarm_pkg::LANE_SO] = phase_to_lane(ph_om);
    front_d[tarm_pkg::LANE_CO] = phase_to_lane(ph_om + tarm_pkg::PHASE_QUARTER);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_SQ]) begin
      for (int l = 0; l < NL; l++) begin
        square_q[l].neg <= front_q[l].neg;
        square_q[l].t   <= front_q[l].t;
        square_q[l].t2  <= tarm_pkg::q30_mul(front_q[l].t, front_q[l].t);
        square_q[l].h   <= tarm_pkg::COEF_C9;
      end
    end
  end

  logic signed [tarm_pkg::SIN_W-1:0] sine[NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign chain[0][l] = square_q[l];
    for (genvar c = 0; c < NC; c++) begin : g_cell
      tarm_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv[STG_C0+c]),
        .coef_i (tarm_pkg::HORNER_COEF[c]),
        .lane_i (chain[c][l]),
        .lane_o (chain[c+1][l])
      );
    end
    tarm_finish u_finish (
      .clk_i  (clk_i),
      .en_i   (adv[STG_FN]),
      .lane_i (chain[NC][l]),
      .sine_o (sine[l])
    );
  end

  function automatic logic signed [tarm_pkg::PROD_W-1:0] rnd_prod(
      input logic signed [tarm_pkg::SIN_W-1:0] a,
      input logic signed [tarm_pkg::SIN_W-1:0] b);
    logic signed [tarm_pkg::PROD_W-1:0] prod;
    prod = a * b;
    prod = prod + tarm_pkg::PROD_HALF;
    return prod >>> tarm_pkg::OUT_FRAC_BITS;
  endfunction

  function automatic logic [tarm_pkg::FIELD_W-1:0] to_field(
      input logic signed [tarm_pkg::PROD_W-1:0] v);
    return v[tarm_pkg::FIELD_W-1:0];
  endfunction

  tarm_pkg::out_item_t out_d, out_q;
  logic signed [tarm_pkg::SIN_W-1:0] sc, cc, so, co;

  always_comb begin
    sc = sine[tarm_pkg::LANE_SC];
    cc = sine[tarm_pkg::LANE_CC];
    so = sine[tarm_pkg::LANE_SO];
    co = sine[tarm_pkg::LANE_CO];
    out_d.r00 = to_field(tarm_pkg::PROD_W'(co));
    out_d.r01 = '0;
    out_d.r02 = to_field(tarm_pkg::PROD_W'(so));
    out_d.r10 = to_field(rnd_prod(sc, so));
    out_d.r11 = to_field(tarm_pkg::PROD_W'(cc));
    out_d.r12 = to_field(-rnd_prod(sc, co));
    out_d.r20 = to_field(-rnd_prod(cc, so));
    out_d.r21 = to_field(tarm_pkg::PROD_W'(sc));
    out_d.r22 = to_field(rnd_prod(cc, co));
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_OT]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/tarm_cell.sv =====
// One polynomial cell: a single Horner step of the sine series for one lane.
`timescale 1ns / 1ps

module tarm_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tarm_pkg::T_W-1:0]     coef_i,
  input  tarm_pkg::lane_t              lane_i,
  output tarm_pkg::lane_t              lane_o
);

  tarm_pkg::lane_t lane_d, lane_q;

  always_comb begin
    lane_d   = lane_i;
    lane_d.h = coef_i - tarm_pkg::q30_mul(lane_i.t2, lane_i.h);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== design/tarm_finish.sv =====
// Final sine stage: last product, rounding, saturation and quadrant sign for one lane.
`timescale 1ns / 1ps

module tarm_finish (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  tarm_pkg::lane_t                     lane_i,
  output logic signed [tarm_pkg::SIN_W-1:0]   sine_o
);

  logic [tarm_pkg::T_W:0]             s_wide;
  logic [tarm_pkg::T_W:0]             s_rnd;
  logic [tarm_pkg::SIN_W-2:0]         mag;
  logic signed [tarm_pkg::SIN_W-1:0]  sine_d, sine_q;

  always_comb begin
    s_wide = {1'b0, tarm_pkg::q30_mul(lane_i.t, lane_i.h)};
    s_rnd  = (s_wide + tarm_pkg::RND_HALF) >> tarm_pkg::ROUND_SH;
    mag    = (s_rnd > tarm_pkg::SAT_ONE) ? tarm_pkg::SAT_ONE[tarm_pkg::SIN_W-2:0]
                                         : s_rnd[tarm_pkg::SIN_W-2:0];
    sine_d = lane_i.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the two-angle rotation matrix with a random handshake.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PAIRS = 1200;
  localparam int unsigned FIRST_SPLIT = 400;
  localparam int unsigned SECOND_SPLIT = 800;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned NUM_CORNERS = 17;

  localparam longint unsigned TURN_Q30 = 64'd1073741824;
  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598668;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172272;
  localparam longint unsigned UNIT_Q14 = 64'd16384;
  localparam logic [31:0] QUARTER_PHASE = 32'h4000_0000;

  localparam logic [15:0] CHI_SET [NUM_CORNERS] = '{
      16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h8000,
      16'h7FFF, 16'h2000, 16'hFFFF, 16'h0001, 16'h0000, 16'h4000,
      16'h8000, 16'h0000, 16'h6000, 16'h5555, 16'hAAAA};
  localparam logic [15:0] OMEGA_SET [NUM_CORNERS] = '{
      16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'hE000, 16'h0001, 16'hFFFF, 16'h4000, 16'h0000,
      16'h0000, 16'h8000, 16'hA000, 16'hAAAA, 16'h5555};

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  tarm_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  tarm_pkg::out_item_t out_data_o;

  tarm_pkg::in_item_t angle_pairs[$];
  tarm_pkg::out_item_t expected_matrices[$];
  int unsigned sent_count;
  int unsigned received_count;
  int unsigned cycle_count;
  int unsigned error_count;
  bit in_taken;

  string entry_names[NUM_ENTRIES] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21",
                                      "r22"};

  two_angle_rotation_matrix dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  function automatic longint unsigned scaled_q30(input longint unsigned a,
                                                 input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint fixed_sine(input logic [31:0] phase);
    logic [1:0] quad;
    longint unsigned pos;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned h;
    longint unsigned s;
    quad = phase[31:30];
    pos = longint'(phase[29:0]);
    t = quad[0] ? TURN_Q30 - pos : pos;
    t2 = scaled_q30(t, t);
    h = SIN_C7 - scaled_q30(t2, SIN_C9);
    h = SIN_C5 - scaled_q30(t2, h);
    h = SIN_C3 - scaled_q30(t2, h);
    h = SIN_C1 - scaled_q30(t2, h);
    s = scaled_q30(t, h);
    s = (s + 64'd32768) >> 16;
    if (s > UNIT_Q14) begin
      s = UNIT_Q14;
    end
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint q14_product(input longint a, input longint b);
    return (a * b + 64'sd8192) >>> 14;
  endfunction

  function automatic tarm_pkg::out_item_t rotation_of(input tarm_pkg::in_item_t pair);
    logic [31:0] chi_phase;
    logic [31:0] omega_phase;
    longint sin_chi;
    longint cos_chi;
    longint sin_omega;
    longint cos_omega;
    tarm_pkg::out_item_t m;
    chi_phase = {pair.chi_angle, 16'h0000};
    omega_phase = {pair.omega_angle, 16'h0000};
    sin_chi = fixed_sine(chi_phase);
    cos_chi = fixed_sine(chi_phase + QUARTER_PHASE);
    sin_omega = fixed_sine(omega_phase);
    cos_omega = fixed_sine(omega_phase + QUARTER_PHASE);
    m.r00 = 16'(cos_omega);
    m.r01 = '0;
    m.r02 = 16'(sin_omega);
    m.r10 = 16'(q14_product(sin_chi, sin_omega));
    m.r11 = 16'(cos_chi);
    m.r12 = 16'(-q14_product(sin_chi, cos_omega));
    m.r20 = 16'(-q14_product(cos_chi, sin_omega));
    m.r21 = 16'(sin_chi);
    m.r22 = 16'(q14_product(cos_chi, cos_omega));
    return m;
  endfunction

  function automatic logic [15:0] random_angle();
    logic [15:0] a;
    if ($urandom_range(99) < 70) begin
      a = 16'($urandom);
    end else begin
      a = 16'($urandom_range(7) * 8192 + $urandom_range(8) - 4);
    end
    return a;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    int unsigned sender_idle;
    int unsigned receiver_idle;
    sender_idle = (sent_count < FIRST_SPLIT) ? 38 : (sent_count < SECOND_SPLIT) ? 87 : 0;
    receiver_idle = (received_count < FIRST_SPLIT) ? 87 :
                    (received_count < SECOND_SPLIT) ? 38 : 0;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < receiver_idle);
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (angle_pairs.size() > 0 && $urandom_range(99) >= sender_idle) begin
          in_valid_i <= 1'b1;
          in_data_i <= angle_pairs.pop_front();
          sent_count++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_matrices.push_back(rotation_of(in_data_i));
      in_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tarm_pkg::out_item_t want;
    logic [143:0] want_bits;
    logic [143:0] got_bits;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      received_count++;
      if (expected_matrices.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer, actual %h", $time, out_data_o);
      end else begin
        want = expected_matrices.pop_front();
        want_bits = want;
        got_bits = out_data_o;
        for (int f = 0; f < NUM_ENTRIES; f++) begin
          if (got_bits[143 - 16 * f -: 16] !== want_bits[143 - 16 * f -: 16]) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, entry_names[f],
                     $signed(want_bits[143 - 16 * f -: 16]),
                     $signed(got_bits[143 - 16 * f -: 16]));
          end
        end
      end
    end
  end

  initial begin
    tarm_pkg::in_item_t pair;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    in_taken = 1'b0;
    sent_count = 0;
    received_count = 0;
    cycle_count = 0;
    error_count = 0;
    rst_ni = 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pair.chi_angle = CHI_SET[i];
      pair.omega_angle = OMEGA_SET[i];
      angle_pairs.push_back(pair);
    end
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      pair.chi_angle = random_angle();
      pair.omega_angle = random_angle();
      angle_pairs.push_back(pair);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (angle_pairs.size() > 0 || in_valid_i || expected_matrices.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tarm_pkg.sv
design/tarm_cell.sv
design/tarm_finish.sv
design/two_angle_rotation_matrix.sv
bench/tb.sv
